### sv/scl_pkg.sv
`timescale 1ns / 1ps
// scl_pkg: event codes, command codes, byte constants and the keyword table
// for the serial command line parser. No dependencies.

package scl_pkg;

  // default line buffer depth (one slot is kept free, as in the line protocol)
  localparam int LINE_CAPACITY_DEF = 40;

  // event codes
  localparam logic [2:0] EV_ECHO    = 3'd0;
  localparam logic [2:0] EV_ERASE   = 3'd1;
  localparam logic [2:0] EV_COMMAND = 3'd2;
  localparam logic [2:0] EV_USAGE   = 3'd3;
  localparam logic [2:0] EV_UNKNOWN = 3'd4;
  localparam logic [2:0] EV_HELP    = 3'd5;
  localparam logic [2:0] EV_DISCARD = 3'd6;
  localparam logic [2:0] EV_BLANK   = 3'd7;

  // command codes
  localparam logic [1:0] CMD_RATE   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_STOP   = 2'd2;
  localparam logic [1:0] CMD_STATUS = 2'd3;

  // byte constants
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // keyword slots
  localparam int NUM_KW = 6;
  localparam logic [2:0] KW_RATE   = 3'd0;
  localparam logic [2:0] KW_START  = 3'd1;
  localparam logic [2:0] KW_STOP   = 3'd2;
  localparam logic [2:0] KW_STATUS = 3'd3;
  localparam logic [2:0] KW_HELP   = 3'd4;
  localparam logic [2:0] KW_QUERY  = 3'd5;

  // keyword length in bytes
  function automatic logic [2:0] kw_len(input logic [2:0] idx);
    logic [2:0] n;
    case (idx)
      KW_RATE:   n = 3'd4;
      KW_START:  n = 3'd5;
      KW_STOP:   n = 3'd4;
      KW_STATUS: n = 3'd6;
      KW_HELP:   n = 3'd4;
      KW_QUERY:  n = 3'd1;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  // keyword byte at position pos
  function automatic logic [7:0] kw_char(input logic [2:0] idx, input logic [2:0] pos);
    logic [47:0] s;
    logic [7:0]  c;
    case (idx)
      KW_RATE:   s = {8'h00, 8'h00, "e", "t", "a", "r"};
      KW_START:  s = {8'h00, "t", "r", "a", "t", "s"};
      KW_STOP:   s = {8'h00, 8'h00, "p", "o", "t", "s"};
      KW_STATUS: s = {"s", "u", "t", "a", "t", "s"};
      KW_HELP:   s = {8'h00, 8'h00, "p", "l", "e", "h"};
      KW_QUERY:  s = {40'h0, "?"};
      default:   s = 48'h0;
    endcase
    case (pos)
      3'd0:    c = s[7:0];
      3'd1:    c = s[15:8];
      3'd2:    c = s[23:16];
      3'd3:    c = s[31:24];
      3'd4:    c = s[39:32];
      3'd5:    c = s[47:40];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### sv/serial_command_line_parser.sv
`timescale 1ns / 1ps
// serial_command_line_parser: line editor, line buffer and sequential line
// scanner that turns received bytes into event words. Depends on scl_pkg.
//
// Usage:
//   in_valid/in_ready/in_rx_byte carries received serial bytes, one per word.
//   out_valid/out_ready carries zero or one event word per byte:
//   out_event_res, out_echo_char, out_command, out_argument.
//   Printable bytes, backspace/DEL and dropped control bytes are handled in
//   the accepting cycle; an echo, erase or discard word is valid the next
//   cycle. CR or LF on a non-empty line starts a scan of the line buffer,
//   one stored byte per cycle through its single registered read port
//   (at most LINE_CAPACITY-1 stored bytes); the parse word is registered
//   after the scan, once the output register is free. in_ready is low
//   during the scan. CR or LF on an empty line gives no word.
//   The output word sits in a register; a new byte is accepted while it is
//   taken in the same cycle. If the receiver stalls, in_ready stays low
//   until the pending word is taken.
//   Reset (rst_n low, synchronous) empties the line and the output register;
//   the buffer contents themselves are not cleared.

module serial_command_line_parser #(
  parameter int LINE_CAPACITY = scl_pkg::LINE_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_echo_char,
  output logic [1:0]  out_command,
  output logic [31:0] out_argument
);

  import scl_pkg::*;

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam logic [AW-1:0] LEN_MAX = AW'(LINE_CAPACITY - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // scan phases
  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_KW   = 2'd1;
  localparam logic [1:0] PH_GAP  = 2'd2;
  localparam logic [1:0] PH_ARG  = 2'd3;

  logic [7:0] line_mem [LINE_CAPACITY];
  logic [7:0] rd_data_r;

  logic [1:0]        state_r, state_nxt;
  logic [AW-1:0]     len_r, len_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic              pv_r, pv_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [NUM_KW-1:0] flag_r, flag_nxt;
  logic [2:0]        kpos_r, kpos_nxt;
  logic [31:0]       val_r, val_nxt;
  logic              arg_any_r, arg_any_nxt;
  logic              arg_bad_r, arg_bad_nxt;

  logic        ov_r, ov_nxt;
  logic [2:0]  oev_r, oev_nxt;
  logic [7:0]  och_r, och_nxt;
  logic [1:0]  ocmd_r, ocmd_nxt;
  logic [31:0] oarg_r, oarg_nxt;

  logic          in_acc, out_free;
  logic          we;
  logic [AW-1:0] rd_addr;
  logic [7:0]    c;
  logic          c_space, c_digit;
  logic [NUM_KW-1:0] match;

  assign out_free  = !ov_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_event_res = oev_r;
  assign out_echo_char = och_r;
  assign out_command   = ocmd_r;
  assign out_argument  = oarg_r;

  // line buffer, one write and one registered read port
  assign we = in_acc && (in_rx_byte >= CH_SPACE) && (in_rx_byte <= CH_TILDE)
              && (len_r < LEN_MAX);
  assign rd_addr = idx_r;

  always_ff @(posedge clk) begin
    if (we) begin
      line_mem[len_r] <= in_rx_byte;
    end
    rd_data_r <= line_mem[rd_addr];
  end

  // byte classification for the scan
  assign c       = rd_data_r;
  assign c_space = (c == CH_SPACE);
  assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);

  // keyword match at scan end
  always_comb begin
    for (int i = 0; i < NUM_KW; i++) begin
      match[i] = flag_r[i] && (kpos_r == kw_len(3'(i)));
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    pv_nxt      = 1'b0;
    ph_nxt      = ph_r;
    flag_nxt    = flag_r;
    kpos_nxt    = kpos_r;
    val_nxt     = val_r;
    arg_any_nxt = arg_any_r;
    arg_bad_nxt = arg_bad_r;
    ov_nxt      = ov_r && !out_ready;
    oev_nxt     = oev_r;
    och_nxt     = och_r;
    ocmd_nxt    = ocmd_r;
    oarg_nxt    = oarg_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          och_nxt  = 8'h00;
          ocmd_nxt = CMD_RATE;
          oarg_nxt = 32'h0;
          if (in_rx_byte == CH_CR || in_rx_byte == CH_LF) begin
            // start a line scan
            if (len_r != '0) begin
              state_nxt   = S_SCAN;
              idx_nxt     = '0;
              ph_nxt      = PH_LEAD;
              flag_nxt    = '1;
              kpos_nxt    = 3'd0;
              val_nxt     = 32'h0;
              arg_any_nxt = 1'b0;
              arg_bad_nxt = 1'b0;
            end
          end else if (in_rx_byte == CH_DEL || in_rx_byte == CH_BS) begin
            if (len_r != '0) begin
              len_nxt = len_r - AW'(1);
              ov_nxt  = 1'b1;
              oev_nxt = EV_ERASE;
            end
          end else if (in_rx_byte >= CH_SPACE && in_rx_byte <= CH_TILDE) begin
            ov_nxt = 1'b1;
            if (len_r < LEN_MAX) begin
              len_nxt = len_r + AW'(1);
              oev_nxt = EV_ECHO;
              och_nxt = in_rx_byte;
            end else begin
              len_nxt = '0;
              oev_nxt = EV_DISCARD;
            end
          end
        end
      end

      S_SCAN: begin
        // issue the next read
        if (idx_r != len_r) begin
          idx_nxt = idx_r + AW'(1);
          pv_nxt  = 1'b1;
        end else if (!pv_r) begin
          state_nxt = S_DONE;
        end
        // consume the byte read last cycle
        if (pv_r) begin
          logic kw_step, arg_step;
          kw_step  = 1'b0;
          arg_step = 1'b0;
          case (ph_r)
            PH_LEAD: if (!c_space) begin ph_nxt = PH_KW; kw_step = 1'b1; end
            PH_KW:   if (c_space) ph_nxt = PH_GAP; else kw_step = 1'b1;
            PH_GAP:  if (!c_space) begin ph_nxt = PH_ARG; arg_step = 1'b1; end
            PH_ARG:  arg_step = 1'b1;
            default: ph_nxt = PH_LEAD;
          endcase
          if (kw_step) begin
            for (int i = 0; i < NUM_KW; i++) begin
              flag_nxt[i] = flag_r[i] && (kpos_r < kw_len(3'(i)))
                            && (c == kw_char(3'(i), kpos_r));
            end
            if (kpos_r != 3'd7) begin
              kpos_nxt = kpos_r + 3'd1;
            end
          end
          if (arg_step) begin
            arg_any_nxt = 1'b1;
            if (c_digit) begin
              val_nxt = (val_r << 3) + (val_r << 1) + {28'h0, c[3:0]};
            end else begin
              arg_bad_nxt = 1'b1;
            end
          end
        end
      end

      S_DONE: begin
        // report the parse outcome when the output register is free
        if (out_free) begin
          ov_nxt    = 1'b1;
          och_nxt   = 8'h00;
          ocmd_nxt  = CMD_RATE;
          oarg_nxt  = 32'h0;
          len_nxt   = '0;
          state_nxt = S_IDLE;
          if (ph_r == PH_LEAD) begin
            oev_nxt = EV_BLANK;
          end else if (match[KW_RATE]) begin
            if (!arg_any_r || arg_bad_r) begin
              oev_nxt = EV_USAGE;
            end else begin
              oev_nxt  = EV_COMMAND;
              oarg_nxt = val_r;
            end
          end else if (match[KW_START]) begin
            oev_nxt  = EV_COMMAND;
            ocmd_nxt = CMD_START;
          end else if (match[KW_STOP]) begin
            oev_nxt  = EV_COMMAND;
            ocmd_nxt = CMD_STOP;
          end else if (match[KW_STATUS]) begin
            oev_nxt  = EV_COMMAND;
            ocmd_nxt = CMD_STATUS;
          end else if (match[KW_HELP] || match[KW_QUERY]) begin
            oev_nxt = EV_HELP;
          end else begin
            oev_nxt = EV_UNKNOWN;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // scan and output payload registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    ph_r      <= ph_nxt;
    flag_r    <= flag_nxt;
    kpos_r    <= kpos_nxt;
    val_r     <= val_nxt;
    arg_any_r <= arg_any_nxt;
    arg_bad_r <= arg_bad_nxt;
    oev_r     <= oev_nxt;
    och_r     <= och_nxt;
    ocmd_r    <= ocmd_nxt;
    oarg_r    <= oarg_nxt;
  end

endmodule

### verif/tb_serial_command_line_parser.sv
`timescale 1ns / 1ps
// tb_serial_command_line_parser: self-checking bench for the serial command line parser.
// Depends on scl_pkg and serial_command_line_parser; a built-in line editor and parser
// model predicts every event word, which is then checked as it leaves the block.

module tb_serial_command_line_parser;
  import scl_pkg::*;

  localparam int LINE_CAP    = LINE_CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  ch;
    logic [1:0]  cmd;
    logic [31:0] arg;
  } event_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_event_res;
  logic [7:0]  out_echo_char;
  logic [1:0]  out_command;
  logic [31:0] out_argument;

  // model state: edited line and its length
  logic [7:0]  line_buf [0:LINE_CAP-1];
  int          model_fill = 0;

  event_word_t pending_events[$];
  logic [7:0]  line_q[$];
  bit          quiet = 1'b0;
  int          words_sent = 0;
  int          words_checked = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          ev_seen [0:7];

  serial_command_line_parser dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_res (out_event_res),
    .out_echo_char (out_echo_char),
    .out_command   (out_command),
    .out_argument  (out_argument)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               pending_events.size());
      $display("tb_serial_command_line_parser NOT OK");
      $finish;
    end
  end

  // tokenize the stored line and classify it
  function automatic event_word_t parse_line();
    event_word_t w;
    int          p;
    int          kw_n;
    logic [47:0] kw;
    logic [31:0] v;
    w = '0;
    p = 0;
    kw_n = 0;
    kw = '0;
    v = '0;
    while (p < model_fill && line_buf[p] == CH_SPACE) p++;
    if (p >= model_fill) begin
      w.ev = EV_BLANK;
      return w;
    end
    // keyword, first six bytes kept, first byte highest
    while (p < model_fill && line_buf[p] != CH_SPACE) begin
      if (kw_n < 6) kw = {kw[39:0], line_buf[p]};
      kw_n++;
      p++;
    end
    while (p < model_fill && line_buf[p] == CH_SPACE) p++;
    if (kw_n == 4 && kw[31:0] == "rate") begin
      w.ev = (p >= model_fill) ? EV_USAGE : EV_COMMAND;
      w.cmd = CMD_RATE;
      while (p < model_fill) begin
        if (line_buf[p] < CH_ZERO || line_buf[p] > CH_NINE) w.ev = EV_USAGE;
        v = v * 32'd10 + {24'd0, line_buf[p] - CH_ZERO};
        p++;
      end
      if (w.ev == EV_COMMAND) w.arg = v;
    end else if (kw_n == 5 && kw[39:0] == "start") begin
      w.ev = EV_COMMAND;
      w.cmd = CMD_START;
    end else if (kw_n == 4 && kw[31:0] == "stop") begin
      w.ev = EV_COMMAND;
      w.cmd = CMD_STOP;
    end else if (kw_n == 6 && kw == "status") begin
      w.ev = EV_COMMAND;
      w.cmd = CMD_STATUS;
    end else if ((kw_n == 4 && kw[31:0] == "help") || (kw_n == 1 && kw[7:0] == "?")) begin
      w.ev = EV_HELP;
    end else begin
      w.ev = EV_UNKNOWN;
    end
    return w;
  endfunction

  // line editor: returns 1 when the byte yields an event word
  function automatic bit byte_to_event(input logic [7:0] b, output event_word_t w);
    w = '0;
    if (b == CH_CR || b == CH_LF) begin
      if (model_fill == 0) return 1'b0;
      w = parse_line();
      model_fill = 0;
    end else if (b == CH_DEL || b == CH_BS) begin
      if (model_fill == 0) return 1'b0;
      model_fill--;
      w.ev = EV_ERASE;
    end else if (b < CH_SPACE || b > CH_TILDE) begin
      return 1'b0;
    end else if (model_fill < LINE_CAP - 1) begin
      line_buf[model_fill] = b;
      model_fill++;
      w.ev = EV_ECHO;
      w.ch = b;
    end else begin
      model_fill = 0;
      w.ev = EV_DISCARD;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(126, 32));
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void push_digits(input int n);
    repeat (n) line_q.push_back(8'(CH_ZERO + $urandom_range(9, 0)));
  endfunction

  function automatic void push_keyword(input logic [2:0] k);
    case (k)
      KW_RATE:   push_text("rate");
      KW_START:  push_text("start");
      KW_STOP:   push_text("stop");
      KW_STATUS: push_text("status");
      KW_HELP:   push_text("help");
      default:   push_text("?");
    endcase
  endfunction

  // send one word after a random gap and predict its event
  task automatic send_word(input logic [7:0] b);
    int          gap;
    event_word_t w;
    gap = quiet ? 0 : $urandom_range(14, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (byte_to_event(b, w)) pending_events.push_back(w);
    words_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_word(line_q[i]);
    line_q.delete();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result side: random stalls, compare each word with the oldest prediction
  initial begin : result_checker
    int          stall;
    event_word_t want;
    for (int i = 0; i < 8; i++) ev_seen[i] = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(14, 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      words_checked++;
      if (pending_events.size() == 0) begin
        $error("event word with nothing expected: event_res %0d", out_event_res);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        ev_seen[want.ev]++;
        check_field("event_res", 32'(want.ev), 32'(out_event_res));
        check_field("echo_char", 32'(want.ch), 32'(out_echo_char));
        check_field("command", 32'(want.cmd), 32'(out_command));
        check_field("argument", want.arg, out_argument);
      end
    end
  end

  // empty-line corners, erase, dropped control bytes, blank line, swallowed LF
  task automatic test_edit_corners();
    quiet = 1'b0;
    line_q = '{CH_CR, CH_BS, CH_DEL, 8'h00, 8'h1F, 8'h80, 8'hFF,
               CH_TILDE, CH_DEL, CH_SPACE, CH_CR, CH_LF};
    send_line();
  endtask

  // query, unknown keyword and a short rate command
  task automatic test_directed_keywords();
    push_text("?");
    line_q.push_back(CH_LF);
    push_text("x");
    line_q.push_back(CH_CR);
    push_text("rate 9");
    line_q.push_back(CH_CR);
    send_line();
  endtask

  // mostly well-formed command lines with random content, typos and mangled keywords
  task automatic test_command_lines();
    int         first;
    int         pick;
    int         kw_at;
    int         kw_n;
    int         pos;
    int         arg_kind;
    logic [7:0] c;
    first = words_sent;
    while (words_sent - first < 900) begin
      if ($urandom_range(15, 0) == 0) quiet = !quiet;
      if ($urandom_range(3, 0) == 0) repeat ($urandom_range(3, 1)) line_q.push_back(CH_SPACE);
      pick = $urandom_range(9, 0);
      kw_at = line_q.size();
      case (pick)
        0, 1, 2: push_keyword(KW_RATE);
        3:       push_keyword(KW_START);
        4:       push_keyword(KW_STOP);
        5:       push_keyword(KW_STATUS);
        6:       push_keyword(KW_HELP);
        7:       push_keyword(KW_QUERY);
        8: begin
          // near miss of a keyword
          push_keyword(3'($urandom_range(5, 0)));
          kw_n = line_q.size() - kw_at;
          pos = kw_at + $urandom_range(kw_n - 1, 0);
          case ($urandom_range(3, 0))
            0:       line_q[pos] = line_q[pos] ^ 8'h20;
            1:       void'(line_q.pop_back());
            2:       line_q.push_back(8'(97 + $urandom_range(25, 0)));
            default: line_q[pos] = 8'($urandom_range(126, 33));
          endcase
        end
        default: ;
      endcase
      if (pick <= 2) begin
        // rate argument variants
        arg_kind = $urandom_range(7, 0);
        if (arg_kind != 0) repeat ($urandom_range(3, 1)) line_q.push_back(CH_SPACE);
        case (arg_kind)
          0: push_digits($urandom_range(3, 1));
          1: ;
          2: push_text("4294967295");
          3: push_text("4294967296");
          4: begin
            push_digits($urandom_range(6, 1));
            do c = rand_printable(); while (c >= CH_ZERO && c <= CH_NINE);
            line_q.push_back(c);
            push_digits($urandom_range(3, 0));
          end
          5: begin
            push_digits($urandom_range(5, 1));
            line_q.push_back(CH_SPACE);
          end
          default: push_digits($urandom_range(12, 1));
        endcase
      end else if (pick != 9 && $urandom_range(2, 0) == 0) begin
        // trailing text after the keyword
        repeat ($urandom_range(2, 1)) line_q.push_back(CH_SPACE);
        repeat ($urandom_range(8, 1)) line_q.push_back(rand_printable());
      end
      // typo fixed with backspace or DEL
      if ($urandom_range(3, 0) == 0) begin
        pos = $urandom_range(line_q.size(), 0);
        line_q.insert(pos, $urandom_range(1, 0) ? CH_BS : CH_DEL);
        line_q.insert(pos, rand_printable());
      end
      // stray control or high byte
      if ($urandom_range(7, 0) == 0) begin
        do c = 8'($urandom_range(255, 0));
        while ((c >= CH_SPACE && c <= CH_TILDE) || c == CH_DEL || c == CH_BS ||
               c == CH_CR || c == CH_LF);
        line_q.insert($urandom_range(line_q.size(), 0), c);
      end
      case ($urandom_range(2, 0))
        0:       line_q.push_back(CH_CR);
        1:       line_q.push_back(CH_LF);
        default: begin
          line_q.push_back(CH_CR);
          line_q.push_back(CH_LF);
        end
      endcase
      send_line();
    end
  endtask

  // lines near, at and past the buffer capacity
  task automatic test_overflow_lines();
    int n;
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(3, 0) == 0) quiet = !quiet;
      n = (i == 0) ? LINE_CAP - 1 : (i == 1) ? LINE_CAP :
          $urandom_range(LINE_CAP + 5, LINE_CAP - 3);
      repeat (n) line_q.push_back(rand_printable());
      line_q.push_back(CH_CR);
      send_line();
    end
  endtask

  // random bytes over the whole range, biased to printable
  task automatic test_byte_noise();
    for (int i = 0; i < 250; i++) begin
      if ($urandom_range(31, 0) == 0) quiet = !quiet;
      send_word($urandom_range(1, 0) ? rand_printable() : 8'($urandom_range(255, 0)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_edit_corners();
    test_directed_keywords();
    test_command_lines();
    test_overflow_lines();
    test_byte_noise();
    in_valid <= 1'b0;
    quiet = 1'b0;
    // drain, then watch for stray words
    while (pending_events.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("%0d bytes sent, %0d event words checked, %0d mismatches",
             words_sent, words_checked, mismatches);
    $display("echo %0d erase %0d command %0d usage %0d unknown %0d help %0d discard %0d blank %0d",
             ev_seen[EV_ECHO], ev_seen[EV_ERASE], ev_seen[EV_COMMAND], ev_seen[EV_USAGE],
             ev_seen[EV_UNKNOWN], ev_seen[EV_HELP], ev_seen[EV_DISCARD], ev_seen[EV_BLANK]);
    if (mismatches == 0) begin
      $display("tb_serial_command_line_parser OK");
    end else begin
      $display("tb_serial_command_line_parser NOT OK");
    end
    $finish;
  end

endmodule
